FILE: sv/bah_pkg.sv
// Shared types and constants for the bond angle histogram.
// Request and result payload structs, operation codes and datapath widths.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bah_pkg;

    localparam int NUM_BINS_DEF = 360;

    localparam int COORD_W = 24;
    localparam int REG_W   = 23;
    localparam int SEL_W   = 9;
    localparam int CNT_W   = 32;

    // datapath widths
    localparam int D_W   = 26;   // displacement after minimum image
    localparam int P_W   = 52;   // signed product of the shared multiplier
    localparam int S_W   = 50;   // squared distance
    localparam int R_W   = 25;   // distance
    localparam int DEN_W = 51;   // 2 * r12 * r13
    localparam int N_W   = 52;   // s12 + s13 - s23, signed
    localparam int C_W   = 32;   // cosine, Q2.30
    localparam int Q_W   = 31;   // cosine magnitude

    localparam int DIV_STEPS  = 30;
    localparam int SQRT_START = 48;

    localparam logic [S_W-1:0] MIN_SQ  = S_W'(4295);
    localparam logic [63:0]    PI_Q30  = 64'd3373259425;
    localparam logic [63:0]    ONE_Q30 = 64'd1 << 30;

    localparam logic [1:0] OP_ACC   = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;
    localparam logic [1:0] OP_NOP   = 2'd3;

    typedef struct packed {
        logic [1:0]                operation;
        logic signed [COORD_W-1:0] center_x;
        logic signed [COORD_W-1:0] center_y;
        logic signed [COORD_W-1:0] center_z;
        logic signed [COORD_W-1:0] first_x;
        logic signed [COORD_W-1:0] first_y;
        logic signed [COORD_W-1:0] first_z;
        logic signed [COORD_W-1:0] second_x;
        logic signed [COORD_W-1:0] second_y;
        logic signed [COORD_W-1:0] second_z;
        logic [SEL_W-1:0]          bin_select;
    } t_req;

    typedef struct packed {
        logic             counted;
        logic [SEL_W-1:0] bin_index;
        logic [CNT_W-1:0] bin_count;
        logic [CNT_W-1:0] total_count;
    } t_res;

endpackage

`default_nettype wire

FILE: sv/bond_angle_histogram.sv
// Bond angle histogram: minimum-image distances, cosine, bin search and a
// histogram RAM with read-modify-write. Depends on bah_pkg.
//
// One request at a time; busy stays high until the result is ready, and the
// result strobe comes in the first cycle that busy is low. An accepted triple
// holds busy through the nine displacements through the shared multiplier, the
// cutoff test, the two iterative square roots, the denominator, the
// bit-serial cosine division (skipped when the cosine saturates), the
// bin-edge search and the RAM read and write-back. A rejected triple holds
// busy through the displacements and the cutoff test, a read through the RAM
// read, and a no-op only through its own state. A clear sweeps the RAM one
// entry per cycle, and the same sweep runs after reset before the first
// request is taken. The result strobe lasts one cycle and cannot be stalled;
// configuration may be written at any time the block is idle.
`timescale 1ns / 1ps
`default_nettype none

module bond_angle_histogram #(
    parameter int NUM_BINS = bah_pkg::NUM_BINS_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         start,
    input  wire bah_pkg::t_req i_req,
    output logic              busy,
    output logic              o_res_valid,
    output bah_pkg::t_res     o_res,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [2:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    import bah_pkg::*;

    localparam int AW = $clog2(NUM_BINS);
    localparam logic [AW-1:0] LAST = AW'(NUM_BINS - 1);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_CLR  = 4'd1;
    localparam logic [3:0] S_DISP = 4'd2;
    localparam logic [3:0] S_LIM  = 4'd3;
    localparam logic [3:0] S_CHK  = 4'd4;
    localparam logic [3:0] S_SQRT = 4'd5;
    localparam logic [3:0] S_DEN  = 4'd6;
    localparam logic [3:0] S_DIV0 = 4'd7;
    localparam logic [3:0] S_DIV  = 4'd8;
    localparam logic [3:0] S_SA   = 4'd9;
    localparam logic [3:0] S_SC   = 4'd10;
    localparam logic [3:0] S_BRD  = 4'd11;
    localparam logic [3:0] S_BWR  = 4'd12;
    localparam logic [3:0] S_RD1  = 4'd13;
    localparam logic [3:0] S_RD2  = 4'd14;
    localparam logic [3:0] S_NOP  = 4'd15;

    localparam logic [2:0] P_DIFF = 3'd0;
    localparam logic [2:0] P_POS  = 3'd1;
    localparam logic [2:0] P_NEG  = 3'd2;
    localparam logic [2:0] P_MUL  = 3'd3;
    localparam logic [2:0] P_ACC  = 3'd4;

    // cos(e*pi/NUM_BINS) for the first quadrant, truncating 11-term series
    function automatic logic signed [C_W-1:0] cos_quad(input int e);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        x    = (64'(e) * PI_Q30) / NUM_BINS;
        x2   = (x * x) >> 30;
        term = ONE_Q30;
        sum  = $signed(ONE_Q30);
        term = ((term * x2) >> 30) / 2;   sum = sum - $signed(term);
        term = ((term * x2) >> 30) / 12;  sum = sum + $signed(term);
        term = ((term * x2) >> 30) / 30;  sum = sum - $signed(term);
        term = ((term * x2) >> 30) / 56;  sum = sum + $signed(term);
        term = ((term * x2) >> 30) / 90;  sum = sum - $signed(term);
        term = ((term * x2) >> 30) / 132; sum = sum + $signed(term);
        term = ((term * x2) >> 30) / 182; sum = sum - $signed(term);
        term = ((term * x2) >> 30) / 240; sum = sum + $signed(term);
        term = ((term * x2) >> 30) / 306; sum = sum - $signed(term);
        term = ((term * x2) >> 30) / 380; sum = sum + $signed(term);
        if (sum < 0) begin
            sum = 0;
        end
        if (sum > $signed(ONE_Q30)) begin
            sum = $signed(ONE_Q30);
        end
        return C_W'(sum);
    endfunction

    function automatic logic signed [C_W-1:0] edge_value(input int e);
        logic signed [C_W-1:0] v;
        if (e == 0) begin
            v = C_W'(ONE_Q30);
        end else if (2 * e == NUM_BINS) begin
            v = '0;
        end else if (2 * e < NUM_BINS) begin
            v = cos_quad(e);
        end else begin
            v = -cos_quad(NUM_BINS - e);
        end
        return v;
    endfunction

    logic signed [C_W-1:0] edge_rom [NUM_BINS];
    for (genvar g = 0; g < NUM_BINS; g++) begin : g_rom
        assign edge_rom[g] = edge_value(g);
    end

    // configuration
    logic [REG_W-1:0] r_box;
    logic [REG_W-1:0] r_cut;
    logic             cfg_wr;

    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;
    assign prdata = paddr[2] ? {(32 - REG_W)'(0), r_cut} : {(32 - REG_W)'(0), r_box};

    // control and datapath registers
    logic [3:0]              r_state;
    t_req                    r_req;
    logic [2:0]              r_ph;
    logic [1:0]              r_ax;
    logic [1:0]              r_pair;
    logic signed [D_W-1:0]   r_d;
    logic signed [P_W-1:0]   r_prod;
    logic [S_W-1:0]          r_s [3];
    logic signed [N_W-1:0]   r_n;
    logic [S_W-1:0]          r_sv;
    logic [S_W-1:0]          r_sr;
    logic [S_W-1:0]          r_sb;
    logic                    r_sidx;
    logic [R_W-1:0]          r_r12;
    logic [R_W-1:0]          r_r13;
    logic [DEN_W-1:0]        r_den;
    logic [DEN_W-1:0]        r_rem;
    logic [Q_W-1:0]          r_q;
    logic                    r_neg;
    logic [4:0]              r_cnt;
    logic [AW-1:0]           r_k;
    logic [AW-1:0]           r_bit;
    logic signed [C_W-1:0]   r_edge;
    logic [AW-1:0]           r_ca;
    logic                    r_clr_res;
    logic [CNT_W-1:0]        r_total;
    logic                    r_out_valid;
    t_res                    r_res;

    // histogram RAM
    logic [CNT_W-1:0]        r_mem [NUM_BINS];
    logic [CNT_W-1:0]        r_rdata;
    logic                    ram_we;
    logic [AW-1:0]           ram_wa;
    logic [CNT_W-1:0]        ram_wd;
    logic [AW-1:0]           ram_ra;

    // displacement operand select
    logic signed [COORD_W-1:0] ctr [3];
    logic signed [COORD_W-1:0] fst [3];
    logic signed [COORD_W-1:0] snd [3];
    logic signed [COORD_W-1:0] pa;
    logic signed [COORD_W-1:0] pb;

    assign ctr[0] = r_req.center_x;
    assign ctr[1] = r_req.center_y;
    assign ctr[2] = r_req.center_z;
    assign fst[0] = r_req.first_x;
    assign fst[1] = r_req.first_y;
    assign fst[2] = r_req.first_z;
    assign snd[0] = r_req.second_x;
    assign snd[1] = r_req.second_y;
    assign snd[2] = r_req.second_z;
    assign pa = (r_pair == 2'd2) ? fst[r_ax] : ctr[r_ax];
    assign pb = (r_pair == 2'd0) ? fst[r_ax] : snd[r_ax];

    logic signed [D_W:0]   d_dbl;
    logic signed [D_W:0]   box_w;
    logic signed [D_W-1:0] box_d;

    assign d_dbl = {r_d, 1'b0};
    assign box_w = $signed({(D_W + 1 - REG_W)'(0), r_box});
    assign box_d = $signed({(D_W - REG_W)'(0), r_box});

    // shared multiplier
    logic signed [D_W-1:0] mul_a;
    logic signed [D_W-1:0] mul_b;
    logic signed [P_W-1:0] mul_p;

    always_comb begin
        case (r_state)
            S_LIM: begin
                mul_a = $signed({(D_W - REG_W)'(0), r_cut});
                mul_b = $signed({(D_W - REG_W)'(0), r_cut});
            end
            S_DEN: begin
                mul_a = $signed({(D_W - R_W)'(0), r_r12});
                mul_b = $signed({(D_W - R_W)'(0), r_r13});
            end
            default: begin
                mul_a = r_d;
                mul_b = r_d;
            end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    // cutoff and minimum-distance test
    logic [S_W-1:0] lim;
    logic           reject;

    assign lim    = r_prod[S_W-1:0];
    assign reject = (r_s[0] > lim) || (r_s[1] > lim) || (r_s[0] < MIN_SQ) || (r_s[1] < MIN_SQ);

    // square root step
    logic [S_W-1:0] sq_t;
    logic           sq_ge;
    logic [S_W-1:0] sq_r;

    assign sq_t  = r_sr + r_sb;
    assign sq_ge = r_sv >= sq_t;
    assign sq_r  = sq_ge ? ((r_sr >> 1) + r_sb) : (r_sr >> 1);

    // division setup and step
    logic [DEN_W-1:0] den_w;
    logic [N_W-1:0]   mag;
    logic [DEN_W:0]   rem2;
    logic             dv_ge;
    logic [DEN_W:0]   rem_sub;

    assign den_w   = {r_prod[DEN_W-2:0], 1'b0};
    assign mag     = r_n[N_W-1] ? N_W'($unsigned(-r_n)) : N_W'($unsigned(r_n));
    assign rem2    = {r_rem, 1'b0};
    assign dv_ge   = rem2 >= {1'b0, r_den};
    assign rem_sub = rem2 - {1'b0, r_den};

    logic signed [C_W-1:0] cval;
    assign cval = r_neg ? -$signed({1'b0, r_q}) : $signed({1'b0, r_q});

    // bin search and counters
    logic [AW-1:0]    cand;
    logic [CNT_W-1:0] bin_inc;
    logic [CNT_W-1:0] tot_inc;
    logic             sel_ok;

    assign cand    = r_k | r_bit;
    assign bin_inc = (&r_rdata) ? r_rdata : r_rdata + CNT_W'(1);
    assign tot_inc = (&r_total) ? r_total : r_total + CNT_W'(1);
    assign sel_ok  = {(32 - SEL_W)'(0), r_req.bin_select} < 32'(NUM_BINS);

    always_comb begin
        ram_we = 1'b0;
        ram_wa = r_k;
        ram_wd = bin_inc;
        ram_ra = r_k;
        case (r_state)
            S_CLR: begin
                ram_we = 1'b1;
                ram_wa = r_ca;
                ram_wd = '0;
            end
            S_BWR: begin
                ram_we = 1'b1;
            end
            S_RD1: begin
                ram_ra = AW'(r_req.bin_select);
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (ram_we) begin
            r_mem[ram_wa] <= ram_wd;
        end
        r_rdata <= r_mem[ram_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_ca        <= '0;
            r_clr_res   <= 1'b0;
            r_total     <= '0;
            r_box       <= '0;
            r_cut       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= 1'b0;
            if (cfg_wr) begin
                if (paddr[2]) begin
                    r_cut <= pwdata[REG_W-1:0];
                end else begin
                    r_box <= pwdata[REG_W-1:0];
                end
            end
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_req  <= i_req;
                        r_ph   <= P_DIFF;
                        r_ax   <= '0;
                        r_pair <= '0;
                        r_s[0] <= '0;
                        r_s[1] <= '0;
                        r_s[2] <= '0;
                        case (i_req.operation)
                            OP_ACC: begin
                                r_state <= S_DISP;
                            end
                            OP_READ: begin
                                r_state <= S_RD1;
                            end
                            OP_CLEAR: begin
                                r_total   <= '0;
                                r_ca      <= '0;
                                r_clr_res <= 1'b1;
                                r_state   <= S_CLR;
                            end
                            default: begin
                                r_state <= S_NOP;
                            end
                        endcase
                    end
                end
                S_CLR: begin
                    r_ca <= r_ca + AW'(1);
                    if (r_ca == LAST) begin
                        r_state     <= S_IDLE;
                        r_out_valid <= r_clr_res;
                        r_res       <= '0;
                    end
                end
                S_DISP: begin
                    case (r_ph)
                        P_DIFF: begin
                            r_d  <= D_W'(pa) - D_W'(pb);
                            r_ph <= P_POS;
                        end
                        P_POS: begin
                            if (d_dbl > box_w) begin
                                r_d <= r_d - box_d;
                            end
                            r_ph <= P_NEG;
                        end
                        P_NEG: begin
                            if (d_dbl < -box_w) begin
                                r_d <= r_d + box_d;
                            end
                            r_ph <= P_MUL;
                        end
                        P_MUL: begin
                            r_prod <= mul_p;
                            r_ph   <= P_ACC;
                        end
                        default: begin
                            r_s[r_pair] <= r_s[r_pair] + r_prod[S_W-1:0];
                            r_ph        <= P_DIFF;
                            if (r_ax == 2'd2) begin
                                r_ax   <= '0;
                                r_pair <= r_pair + 2'd1;
                                if (r_pair == 2'd2) begin
                                    r_state <= S_LIM;
                                end
                            end else begin
                                r_ax <= r_ax + 2'd1;
                            end
                        end
                    endcase
                end
                S_LIM: begin
                    r_prod  <= mul_p;
                    r_n     <= $signed({(N_W - S_W)'(0), r_s[0]})
                             + $signed({(N_W - S_W)'(0), r_s[1]});
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    if (reject) begin
                        // drop the triple, report the current total
                        r_out_valid <= 1'b1;
                        r_res       <= '{counted: 1'b0, bin_index: '0, bin_count: '0,
                                         total_count: r_total};
                        r_state     <= S_IDLE;
                    end else begin
                        r_n     <= r_n - $signed({(N_W - S_W)'(0), r_s[2]});
                        r_sv    <= r_s[0];
                        r_sr    <= '0;
                        r_sb    <= S_W'(1) << SQRT_START;
                        r_sidx  <= 1'b0;
                        r_state <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    r_sv <= sq_ge ? (r_sv - sq_t) : r_sv;
                    r_sr <= sq_r;
                    r_sb <= r_sb >> 2;
                    if (r_sb[0]) begin
                        if (!r_sidx) begin
                            r_r12  <= sq_r[R_W-1:0];
                            r_sv   <= r_s[1];
                            r_sr   <= '0;
                            r_sb   <= S_W'(1) << SQRT_START;
                            r_sidx <= 1'b1;
                        end else begin
                            r_r13   <= sq_r[R_W-1:0];
                            r_state <= S_DEN;
                        end
                    end
                end
                S_DEN: begin
                    r_prod  <= mul_p;
                    r_state <= S_DIV0;
                end
                S_DIV0: begin
                    r_den <= den_w;
                    r_neg <= r_n[N_W-1];
                    r_cnt <= '0;
                    r_k   <= '0;
                    r_bit <= AW'(1) << (AW - 1);
                    if (mag >= {1'b0, den_w}) begin
                        // saturate the cosine magnitude at one
                        r_q     <= Q_W'(ONE_Q30);
                        r_state <= S_SA;
                    end else begin
                        r_q     <= '0;
                        r_rem   <= mag[DEN_W-1:0];
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_rem <= dv_ge ? rem_sub[DEN_W-1:0] : rem2[DEN_W-1:0];
                    r_q   <= {r_q[Q_W-2:0], dv_ge};
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'(DIV_STEPS - 1)) begin
                        r_state <= S_SA;
                    end
                end
                S_SA: begin
                    if (cand <= LAST) begin
                        r_edge  <= edge_rom[cand];
                        r_state <= S_SC;
                    end else begin
                        r_bit <= r_bit >> 1;
                        if (r_bit[0]) begin
                            r_state <= S_BRD;
                        end
                    end
                end
                S_SC: begin
                    // edges fall with index, so bins below the hit form a prefix
                    if (cval <= r_edge) begin
                        r_k <= cand;
                    end
                    r_bit   <= r_bit >> 1;
                    r_state <= r_bit[0] ? S_BRD : S_SA;
                end
                S_BRD: begin
                    r_state <= S_BWR;
                end
                S_BWR: begin
                    r_total           <= tot_inc;
                    r_out_valid       <= 1'b1;
                    r_res.counted     <= 1'b1;
                    r_res.bin_index   <= SEL_W'(r_k);
                    r_res.bin_count   <= bin_inc;
                    r_res.total_count <= tot_inc;
                    r_state           <= S_IDLE;
                end
                S_RD1: begin
                    r_state <= S_RD2;
                end
                S_RD2: begin
                    r_out_valid       <= 1'b1;
                    r_res.counted     <= 1'b0;
                    r_res.bin_index   <= r_req.bin_select;
                    r_res.bin_count   <= sel_ok ? r_rdata : '0;
                    r_res.total_count <= r_total;
                    r_state           <= S_IDLE;
                end
                default: begin
                    r_out_valid <= 1'b1;
                    r_res       <= '{counted: 1'b0, bin_index: '0, bin_count: '0,
                                     total_count: r_total};
                    r_state     <= S_IDLE;
                end
            endcase
        end
    end

    assign busy        = (r_state != S_IDLE);
    assign o_res_valid = r_out_valid;
    assign o_res       = r_res;

endmodule

`default_nettype wire

FILE: sv/bah_check.sv
// Port-level checks for the bond angle histogram, bound to the top level.
// Depends on bah_pkg and bond_angle_histogram.
`timescale 1ns / 1ps
`default_nettype none

module bah_check (
    input wire logic    i_clk,
    input wire logic    i_rst_n,
    input wire logic    start,
    input wire logic    busy,
    input wire logic    o_res_valid,
    input wire bah_pkg::t_res o_res
);
    import bah_pkg::*;

    // an accepted request holds the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("request accepted but busy not raised");

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |=> !o_res_valid)
        else $error("result strobe longer than one cycle");

    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> !busy)
        else $error("result shown while still busy");

    a_counted_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_res.counted |-> (o_res.bin_count != '0) && (o_res.total_count != '0))
        else $error("counted triple with zero bin or total");

endmodule

bind bond_angle_histogram bah_check u_bah_check (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .o_res_valid (o_res_valid),
    .o_res       (o_res)
);

`default_nettype wire
